>>> sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define CPG_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cpg_pkg.sv
package cpg_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int COLOUR_BITS = 16;
    localparam logic [COLOUR_BITS-1:0] COLOUR_RESET = 16'hF800;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

>>> sv/cpg_in_if.sv
interface cpg_in_if #(
    parameter int COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius;

    modport source (output valid, req_type, center_x, center_y, radius, input ready);
    modport sink   (input valid, req_type, center_x, center_y, radius, output ready);
endinterface

>>> sv/cpg_out_if.sv
interface cpg_out_if #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [COORD_BITS:0]         pixel_x;
    logic signed [COORD_BITS:0]         pixel_y;
    logic [cpg_pkg::COLOUR_BITS-1:0]    colour;
    logic                               last_of_step;
    logic                               circle_done;

    modport source (output valid, pixel_x, pixel_y, colour, last_of_step, circle_done,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, colour, last_of_step, circle_done,
                    output ready);
endinterface

>>> sv/circle_pixel_generator_unit.sv
// path: first pixel of a step passes through the step queue and the back-end output register
// throughput: one pixel per cycle while the sink is ready; a step gives one to eight
// pixels, set by the back-end pixel sequencer; a start gives no pixel
// a queue of QUEUE_DEPTH steps lets the front accept while pixels drain
// reset: asynchronous active low, idle with colour 0xF800
module circle_pixel_generator_unit #(
    parameter int COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF,
    parameter int QUEUE_DEPTH = cpg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cpg_pkg::COLOUR_BITS-1:0] cfg_wdata,
    cpg_in_if.sink                          in_ch,
    cpg_out_if.source                       out_ch
);
    import cpg_pkg::*;

    localparam int JOB_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + COLOUR_BITS + 1;

    logic                push;
    logic [JOB_BITS-1:0] push_job;
    logic                full;
    logic                pop;
    logic [JOB_BITS-1:0] head_job;
    logic                empty;

    cpg_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_BITS    (JOB_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .push      (push),
        .push_job  (push_job),
        .full      (full)
    );

    cpg_fifo #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_job),
        .empty     (empty)
    );

    cpg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .JOB_BITS    (JOB_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!empty),
        .job       (head_job),
        .pop       (pop),
        .out_ch    (out_ch)
    );
endmodule

>>> sv/cpg_front.sv
module cpg_front #(
    parameter int COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF,
    parameter int JOB_BITS    = 2 * COORD_BITS + 2 * RADIUS_BITS + cpg_pkg::COLOUR_BITS + 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cpg_pkg::COLOUR_BITS-1:0] cfg_wdata,
    cpg_in_if.sink                          in_ch,
    output logic                            push,
    output logic [JOB_BITS-1:0]             push_job,
    input  logic                            full
);
    import cpg_pkg::*;

    localparam int OW = RADIUS_BITS + 2;
    localparam int EW = RADIUS_BITS + 4;

    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [OW-1:0]         x_reg, x_next;
    logic signed [OW-1:0]         y_reg, y_next;
    logic signed [EW-1:0]         e_reg, e_next;
    logic                         active_reg, active_next;
    logic [COLOUR_BITS-1:0]       colour_reg, colour_next;

    logic                         accept;
    logic signed [OW-1:0]         y1;
    logic signed [OW-1:0]         x1;
    logic signed [EW-1:0]         e1;
    logic signed [EW-1:0]         e2;
    logic                         move_x;
    logic                         done;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && in_ch.ready;

    // one midpoint iteration
    always_comb
    begin
        y1     = y_reg + OW'(1);
        e1     = e_reg + EW'(y_reg) + EW'(y1);
        move_x = !e1[EW-1];
        x1     = move_x ? (x_reg - OW'(1)) : x_reg;
        e2     = move_x ? (e1 - EW'(x_reg) - EW'(x1)) : e1;
        done   = x1 < y1;
    end

    assign colour_next = cfg_we ? cfg_wdata : colour_reg;

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        e_next      = e_reg;
        active_next = active_reg;
        push        = 1'b0;
        if (accept)
        begin
            unique case (in_ch.req_type)
                REQ_START:
                begin
                    cx_next     = in_ch.center_x;
                    cy_next     = in_ch.center_y;
                    x_next      = signed'(OW'(in_ch.radius));
                    y_next      = '0;
                    e_next      = -signed'(EW'(in_ch.radius));
                    active_next = 1'b1;
                end
                REQ_STEP:
                begin
                    if (active_reg)
                    begin
                        push        = 1'b1;
                        x_next      = x1;
                        y_next      = y1;
                        e_next      = e2;
                        active_next = !done;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push_job = {cx_reg, cy_reg, x_reg[RADIUS_BITS-1:0], y_reg[RADIUS_BITS-1:0],
                       colour_reg, done};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            e_reg      <= '0;
            active_reg <= 1'b0;
            colour_reg <= COLOUR_RESET;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            e_reg      <= e_next;
            active_reg <= active_next;
            colour_reg <= colour_next;
        end
    end
endmodule

>>> sv/cpg_fifo.sv
module cpg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cpg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import cpg_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

>>> sv/cpg_back.sv
module cpg_back #(
    parameter int COORD_BITS  = cpg_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = cpg_pkg::RADIUS_BITS_DEF,
    parameter int JOB_BITS    = 2 * COORD_BITS + 2 * RADIUS_BITS + cpg_pkg::COLOUR_BITS + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  logic [JOB_BITS-1:0] job,
    output logic                pop,
    cpg_out_if.source           out_ch
);
    import cpg_pkg::*;

    localparam int PW = COORD_BITS + 1;

    logic [COORD_BITS-1:0]  job_cx;
    logic [COORD_BITS-1:0]  job_cy;
    logic [RADIUS_BITS-1:0] job_x;
    logic [RADIUS_BITS-1:0] job_y;
    logic [COLOUR_BITS-1:0] job_colour;
    logic                   job_done;

    logic [2:0]             slot_reg, slot_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PW-1:0]          px_reg, px_next;
    logic [PW-1:0]          py_reg, py_next;
    logic [COLOUR_BITS-1:0] colour_reg, colour_next;
    logic                   last_reg, last_next;
    logic                   done_reg, done_next;

    logic [7:0]             mask;
    logic [2:0]             next_slot;
    logic                   is_last;
    logic [RADIUS_BITS-1:0] a;
    logic [RADIUS_BITS-1:0] b;
    logic [PW-1:0]          cx_e;
    logic [PW-1:0]          cy_e;
    logic [PW-1:0]          a_e;
    logic [PW-1:0]          b_e;
    logic                   load;

    assign {job_cx, job_cy, job_x, job_y, job_colour, job_done} = job;

    // distinct pixels of the eight-way reflection
    always_comb
    begin
        mask[0] = 1'b1;
        mask[1] = |job_x;
        mask[2] = |job_y;
        mask[3] = (|job_x) && (|job_y);
        mask[4] = job_x != job_y;
        mask[5] = (job_x != job_y) && (|job_y);
        mask[6] = (job_x != job_y) && (|job_x);
        mask[7] = (job_x != job_y) && (|job_x) && (|job_y);
    end

    always_comb
    begin
        next_slot = slot_reg;
        is_last   = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            if (mask[i] && (3'(i) > slot_reg))
            begin
                next_slot = 3'(i);
                is_last   = 1'b0;
            end
        end
    end

    always_comb
    begin
        a    = slot_reg[2] ? job_y : job_x;
        b    = slot_reg[2] ? job_x : job_y;
        cx_e = PW'(signed'(job_cx));
        cy_e = PW'(signed'(job_cy));
        a_e  = PW'(a);
        b_e  = PW'(b);
    end

    assign load = job_valid && (!out_valid_reg || out_ch.ready);
    assign pop  = load && is_last;

    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        px_next        = px_reg;
        py_next        = py_reg;
        colour_next    = colour_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            px_next        = slot_reg[0] ? (cx_e - a_e) : (cx_e + a_e);
            py_next        = slot_reg[1] ? (cy_e - b_e) : (cy_e + b_e);
            colour_next    = job_colour;
            last_next      = is_last;
            done_next      = is_last && job_done;
            slot_next      = is_last ? 3'd0 : next_slot;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pixel_x      = px_reg;
    assign out_ch.pixel_y      = py_reg;
    assign out_ch.colour       = colour_reg;
    assign out_ch.last_of_step = last_reg;
    assign out_ch.circle_done  = done_reg;

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        colour_reg <= colour_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

>>> sv/cpg_checker.sv
`include "assert_macros.svh"

module cpg_checker #(
    parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic [cpg_pkg::COLOUR_BITS-1:0] cfg_wdata,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [COORD_BITS:0]             out_px,
    input logic [COORD_BITS:0]             out_py,
    input logic [cpg_pkg::COLOUR_BITS-1:0] out_colour,
    input logic                            out_last,
    input logic                            out_done
);
    import cpg_pkg::*;

    logic [COLOUR_BITS-1:0] colour_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= COLOUR_RESET;
        end
        else if (cfg_we)
        begin
            colour_reg <= cfg_wdata;
        end
    end

    `CPG_ASSERT_PROP(a_done_is_last, clk, rst_n, (out_valid && out_done) |-> out_last, "circle done without last of step")
    `CPG_ASSERT_PROP(a_colour_match, clk, rst_n, out_valid |-> (out_colour == colour_reg), "pixel colour differs from configured colour")
    `CPG_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_px) && $stable(out_py) && $stable(out_last), "stalled pixel changed")

endmodule

bind circle_pixel_generator_unit cpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_cpg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_px     (out_ch.pixel_x),
    .out_py     (out_ch.pixel_y),
    .out_colour (out_ch.colour),
    .out_last   (out_ch.last_of_step),
    .out_done   (out_ch.circle_done)
);

>>> verif/tb.sv
module tb;

    import cpg_pkg::*;

    localparam int CB               = COORD_BITS_DEF;
    localparam int RB               = RADIUS_BITS_DEF;
    localparam int QUIET_CYCLES     = 16;
    localparam int SINK_HOLD_CYCLES = 150;
    localparam int STALL_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE  = 50;

    localparam int KNOWN_PREDICT = -1;
    localparam int KNOWN_NONE    = 0;
    localparam int KNOWN_ONE     = 1;

    typedef struct {
        logic                 req_type;
        logic signed [CB-1:0] center_x;
        logic signed [CB-1:0] center_y;
        logic        [RB-1:0] radius;
    } circle_req_t;

    typedef struct {
        logic signed [CB:0]          pixel_x;
        logic signed [CB:0]          pixel_y;
        logic [COLOUR_BITS-1:0]      colour;
        logic                        last_of_step;
        logic                        circle_done;
    } pixel_t;

    typedef struct {
        logic req_type;
        int   cx;
        int   cy;
        int   rad;
        int   known;
        int   px;
        int   py;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [COLOUR_BITS-1:0] cfg_wdata;

    cpg_in_if  in_ch();
    cpg_out_if out_ch();

    circle_pixel_generator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // walk state of the circle being drawn
    int                     ring_cx;
    int                     ring_cy;
    int                     walk_x;
    int                     walk_y;
    int                     walk_err;
    bit                     drawing;
    logic [COLOUR_BITS-1:0] pen_colour;

    pixel_t        step_pixels[$];
    pixel_t        pixels_due[$];
    directed_row_t directed_rows[$];

    int mismatches;
    int items_done;
    bit sender_burst;
    bit sink_burst;
    bit hold_sink_req;

    function automatic pixel_t make_pixel(int px, int py);
        pixel_t p;
        p.pixel_x      = (CB+1)'(px);
        p.pixel_y      = (CB+1)'(py);
        p.colour       = pen_colour;
        p.last_of_step = 1'b0;
        p.circle_done  = 1'b0;
        return p;
    endfunction

    function automatic void plot_mirrors(int a, int b);
        step_pixels.push_back(make_pixel(ring_cx + a, ring_cy + b));
        if (a != 0)
            step_pixels.push_back(make_pixel(ring_cx - a, ring_cy + b));
        if (b != 0)
            step_pixels.push_back(make_pixel(ring_cx + a, ring_cy - b));
        if (a != 0 && b != 0)
            step_pixels.push_back(make_pixel(ring_cx - a, ring_cy - b));
    endfunction

    function automatic void trace_circle_step(circle_req_t r);
        pixel_t tail;
        step_pixels.delete();
        if (r.req_type == REQ_START)
        begin
            ring_cx  = int'(r.center_x);
            ring_cy  = int'(r.center_y);
            walk_x   = int'(r.radius);
            walk_y   = 0;
            walk_err = -walk_x;
            drawing  = 1'b1;
            return;
        end
        if (!drawing)
            return;
        plot_mirrors(walk_x, walk_y);
        if (walk_x != walk_y)
            plot_mirrors(walk_y, walk_x);
        walk_err += walk_y;
        walk_y++;
        walk_err += walk_y;
        if (walk_err >= 0)
        begin
            walk_err -= walk_x;
            walk_x--;
            walk_err -= walk_x;
        end
        tail = step_pixels.pop_back();
        tail.last_of_step = 1'b1;
        tail.circle_done  = (walk_x < walk_y);
        step_pixels.push_back(tail);
        if (walk_x < walk_y)
            drawing = 1'b0;
    endfunction

    task automatic send_item(circle_req_t r, int known, pixel_t known_pix);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= r.req_type;
        in_ch.center_x <= r.center_x;
        in_ch.center_y <= r.center_y;
        in_ch.radius   <= r.radius;
        do
            @(posedge clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        if (r.req_type == REQ_START || drawing)
            items_done++;
        trace_circle_step(r);
        if (known == KNOWN_PREDICT)
        begin
            foreach (step_pixels[i])
                pixels_due.push_back(step_pixels[i]);
        end
        else if (known == KNOWN_ONE)
            pixels_due.push_back(known_pix);
    endtask

    task automatic settle(int quiet);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (quiet) @(posedge clk);
    endtask

    task automatic write_colour(logic [COLOUR_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pen_colour = value;
    endtask

    function automatic void add_row(logic rt, int cx, int cy, int rad, int known,
                                    int px, int py);
        directed_row_t row;
        row.req_type = rt;
        row.cx       = cx;
        row.cy       = cy;
        row.rad      = rad;
        row.known    = known;
        row.px       = px;
        row.py       = py;
        directed_rows.push_back(row);
    endfunction

    // one start and its steps; sometimes cut short, sometimes plain noise
    task automatic run_circle();
        circle_req_t r;
        pixel_t      unused;
        int          kind;
        int          steps;
        int          cap;
        kind       = $urandom_range(0, 19);
        r.center_x = CB'($urandom);
        r.center_y = CB'($urandom);
        r.radius   = RB'($urandom);
        if (kind < 2)
        begin
            r.req_type = 1'($urandom_range(0, 1));
            send_item(r, KNOWN_PREDICT, unused);
            return;
        end
        r.req_type = REQ_START;
        if (kind < 16)
            r.radius = RB'($urandom_range(0, 24));
        if (kind >= 16)
            cap = $urandom_range(1, 8);
        else if ($urandom_range(0, 3) == 0)
            cap = $urandom_range(0, 6);
        else
            cap = 1 << 20;
        send_item(r, KNOWN_PREDICT, unused);
        steps = 0;
        while (drawing && steps < cap)
        begin
            r.req_type = REQ_STEP;
            r.center_x = CB'($urandom);
            r.center_y = CB'($urandom);
            r.radius   = RB'($urandom);
            send_item(r, KNOWN_PREDICT, unused);
            steps++;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            r.req_type = REQ_STEP;
            send_item(r, KNOWN_PREDICT, unused);
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pixels_due.size() == 0)
        begin
            $error("unexpected pixel at (%0d, %0d)", out_ch.pixel_x, out_ch.pixel_y);
            mismatches++;
        end
        else
        begin
            want = pixels_due.pop_front();
            if (out_ch.pixel_x !== want.pixel_x)
            begin
                $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_ch.pixel_x);
                mismatches++;
            end
            if (out_ch.pixel_y !== want.pixel_y)
            begin
                $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_ch.pixel_y);
                mismatches++;
            end
            if (out_ch.colour !== want.colour)
            begin
                $error("colour: expected %h, got %h", want.colour, out_ch.colour);
                mismatches++;
            end
            if (out_ch.last_of_step !== want.last_of_step)
            begin
                $error("last_of_step: expected %b, got %b", want.last_of_step,
                       out_ch.last_of_step);
                mismatches++;
            end
            if (out_ch.circle_done !== want.circle_done)
            begin
                $error("circle_done: expected %b, got %b", want.circle_done,
                       out_ch.circle_done);
                mismatches++;
            end
        end
    endtask

    // pixel sink with random stalls and one long hold-off on request
    initial
    begin : pixel_sink
        int stall;
        out_ch.ready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            if (hold_sink_req)
            begin
                hold_sink_req = 1'b0;
                stall = SINK_HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
            check_pixel();
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        circle_req_t            r;
        pixel_t                 known_pix;
        logic [COLOUR_BITS-1:0] phase_colour;
        int                     target;
        bit                     paused;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_START;
        in_ch.center_x = '0;
        in_ch.center_y = '0;
        in_ch.radius   = '0;
        ring_cx        = 0;
        ring_cy        = 0;
        walk_x         = 0;
        walk_y         = 0;
        walk_err       = 0;
        drawing        = 1'b0;
        pen_colour     = COLOUR_RESET;
        mismatches     = 0;
        items_done     = 0;
        sender_burst   = 1'b0;
        sink_burst     = 1'b0;
        hold_sink_req  = 1'b0;
        paused         = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(REQ_STEP,   2047,    -1, 1023, KNOWN_NONE,        0,     0);
        add_row(REQ_START,     0,     0,    0, KNOWN_NONE,        0,     0);
        add_row(REQ_STEP,  -2048,     0,    0, KNOWN_ONE,         0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_NONE,        0,     0);
        add_row(REQ_START,  2047, -2048,    0, KNOWN_NONE,        0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_ONE,      2047, -2048);
        add_row(REQ_START, -2048,  2047,    0, KNOWN_NONE,        0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_ONE,     -2048,  2047);
        add_row(REQ_START,     0,     0,    1, KNOWN_NONE,        0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_PREDICT,     0,     0);
        add_row(REQ_START,   100,  -100,    2, KNOWN_NONE,        0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_PREDICT,     0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_PREDICT,     0,     0);
        add_row(REQ_START, -2048, -2048, 1023, KNOWN_NONE,        0,     0);
        add_row(REQ_STEP,   2047,  2047,    0, KNOWN_PREDICT,     0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_PREDICT,     0,     0);
        add_row(REQ_START,  2047,  2047,    3, KNOWN_NONE,        0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_PREDICT,     0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_PREDICT,     0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_PREDICT,     0,     0);
        add_row(REQ_STEP,      0,     0,    0, KNOWN_NONE,        0,     0);

        foreach (directed_rows[i])
        begin
            r.req_type             = directed_rows[i].req_type;
            r.center_x             = CB'(directed_rows[i].cx);
            r.center_y             = CB'(directed_rows[i].cy);
            r.radius               = RB'(directed_rows[i].rad);
            known_pix.pixel_x      = (CB+1)'(directed_rows[i].px);
            known_pix.pixel_y      = (CB+1)'(directed_rows[i].py);
            known_pix.colour       = COLOUR_RESET;
            known_pix.last_of_step = 1'b1;
            known_pix.circle_done  = 1'b1;
            send_item(r, directed_rows[i].known, known_pix);
        end

        for (int p = 0; p < 6; p++)
        begin
            settle(QUIET_CYCLES);
            case (p)
                0:       phase_colour = '0;
                1:       phase_colour = '1;
                3:       phase_colour = 16'h8000;
                4:       phase_colour = 16'h7FFF;
                default: phase_colour = COLOUR_BITS'($urandom);
            endcase
            write_colour(phase_colour);
            sink_burst = (p == 2);
            if (p == 1)
                hold_sink_req = 1'b1;
            target = items_done + ITEMS_PER_PHASE;
            while (items_done < target)
            begin
                sender_burst = (p == 1 || p == 2) ? 1'b1 : ($urandom_range(0, 5) == 0);
                run_circle();
                // sender holds back until every pixel so far has drained
                if (p == 3 && !paused && items_done >= target - ITEMS_PER_PHASE / 2)
                begin
                    settle(0);
                    paused = 1'b1;
                end
            end
        end

        settle(20);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/cpg_pkg.sv
sv/cpg_in_if.sv
sv/cpg_out_if.sv
sv/cpg_front.sv
sv/cpg_fifo.sv
sv/cpg_back.sv
sv/circle_pixel_generator_unit.sv
sv/cpg_checker.sv
verif/tb.sv
